// ----- src/barometer_display_mode_formatter_core_assert.svh -----
// Assertion macros for the checker file.
`ifndef BAROMETER_DISPLAY_MODE_FORMATTER_CORE_ASSERT_SVH
`define BAROMETER_DISPLAY_MODE_FORMATTER_CORE_ASSERT_SVH

// Implication checked on every rising clk edge, off while rst is high.
`define BDMF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BDMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bdmf_pkg.sv -----
package bdmf_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned PRESS_W  = 17;
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned ALT_W    = 16;
  localparam int unsigned VALUE_W  = 14;
  localparam int unsigned DOT_W    = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CHANGE_W = 18;
  localparam int unsigned DEB_W    = 16;

  localparam int unsigned IN_TDATA_W  = 80;  // 77 field bits padded to bytes
  localparam int unsigned OUT_TDATA_W = 40;  // 35 field bits padded to bytes

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE     = 2'd0,
    ACT_BUTTON_ONE = 2'd1,
    ACT_BUTTON_TWO = 2'd2,
    ACT_UNUSED     = 2'd3
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PRESSURE    = 2'd0,
    MODE_DELTA       = 2'd1,
    MODE_TEMPERATURE = 2'd2,
    MODE_ALTITUDE    = 2'd3
  } mode_t;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 16'd200;
  localparam logic [VALUE_W-1:0] DISPLAY_MAX    = 14'd9999;
  localparam logic [DOT_W-1:0]   DOT_POS0       = 3'd0;
  localparam logic [DOT_W-1:0]   DOT_POS1       = 3'd1;
  localparam logic [DOT_W-1:0]   DOT_NONE       = 3'd4;

  // Round to hundreds: (p + 50) / 100 as (x * ceil(2^24 / 100)) >> 24,
  // exact for x below 199728, which covers every 17-bit pressure plus 50.
  localparam logic [PRESS_W:0] ROUND_HALF   = 18'd50;
  localparam logic [PRESS_W:0] RECIP_HUNDRED = 18'd167773;
  localparam int unsigned      RECIP_SHIFT  = 24;
  localparam int unsigned      HUND_W       = 2 * (PRESS_W + 1) - RECIP_SHIFT;

  function automatic logic [VALUE_W-1:0] sat_display(input logic [PRESS_W-1:0] v);
    logic [VALUE_W-1:0] r;
    if (v > {{(PRESS_W - VALUE_W){1'b0}}, DISPLAY_MAX}) begin
      r = DISPLAY_MAX;
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/bdmf_format.sv -----
module bdmf_format
  import bdmf_pkg::*;
(
  input  mode_t                       mode,
  input  logic [PRESS_W-1:0]          pressure,
  input  logic signed [CHANGE_W-1:0]  pressure_change,
  input  logic signed [TEMP_W-1:0]    temp_tenths,
  input  logic signed [ALT_W-1:0]     altitude,
  output logic [VALUE_W-1:0]          display_value,
  output logic [DOT_W-1:0]            dot_code
);

  logic [PRESS_W:0]             rounded;
  logic [2*(PRESS_W+1)-1:0]     product;
  logic [HUND_W-1:0]            hundreds;
  logic [PRESS_W-1:0]           magnitude;
  logic [CHANGE_W-1:0]          negated;
  logic [TEMP_W+2:0]            temp_mag;
  logic [TEMP_W+2:0]            temp_scaled;

  assign rounded  = {1'b0, pressure} + ROUND_HALF;
  assign product  = rounded * RECIP_HUNDRED;
  assign hundreds = product[RECIP_SHIFT +: HUND_W];

  // Delta never reaches -2^17, so the magnitude fits 17 bits.
  assign negated   = -pressure_change;
  assign magnitude = pressure_change[CHANGE_W-1] ? negated[PRESS_W-1:0]
                                                 : pressure_change[PRESS_W-1:0];

  // x10 as x8 + x2 on the non-negative magnitude.
  assign temp_mag    = {4'b0000, temp_tenths[TEMP_W-2:0]};
  assign temp_scaled = (temp_mag << 3) + (temp_mag << 1);

  always_comb begin
    display_value = '0;
    dot_code      = DOT_NONE;
    case (mode)
      MODE_DELTA: begin
        display_value = sat_display(magnitude);
        dot_code      = DOT_NONE;
      end
      MODE_TEMPERATURE: begin
        if (temp_tenths[TEMP_W-1]) begin
          display_value = '0;
          dot_code      = DOT_NONE;
        end else begin
          display_value = sat_display({2'b00, temp_scaled});
          dot_code      = DOT_POS1;
        end
      end
      MODE_ALTITUDE: begin
        if (altitude[ALT_W-1]) begin
          display_value = '0;
        end else begin
          display_value = sat_display({2'b00, altitude[ALT_W-2:0]});
        end
        dot_code = DOT_NONE;
      end
      default: begin
        display_value = sat_display({{(PRESS_W - HUND_W){1'b0}}, hundreds});
        dot_code      = DOT_POS0;
      end
    endcase
  end

endmodule

// ----- src/barometer_display_mode_formatter_core.sv -----
// A sample word accepted on s_axis passes the input register, then the result register.
// One input word per cycle unless a sample waits on a full result register; set by the
// single input and result registers, with mode and debounce state updated in one pass.
// Button words update state and produce no result word.
// Reset (rst, synchronous, active high): mode pressure, debounce 200 ms,
// last-press ticks and previous pressure zero, first-sample flag clear, no words held.
module barometer_display_mode_formatter_core
  import bdmf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Debounce register write port
  input  logic                   cfg_wen,
  input  logic [DEB_W-1:0]       cfg_wdata,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] now_ms, [48:32] pressure, [60:49] temperature in tenths, [76:61] altitude
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] action
  input  logic [ACTION_W-1:0]    s_axis_tuser,
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [13:0] display_value, [16:14] dot_code, [34:17] pressure_change
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] active_mode
  output logic [MODE_W-1:0]      m_axis_tuser
);

  // Input register
  logic                      s1_valid;
  action_t                   s1_action;
  logic [NOW_W-1:0]          s1_now;
  logic [PRESS_W-1:0]        s1_pressure;
  logic signed [TEMP_W-1:0]  s1_temp;
  logic signed [ALT_W-1:0]   s1_alt;

  // Block state
  logic [DEB_W-1:0]          debounce_ms;
  mode_t                     mode;
  mode_t                     mode_next;
  logic                      seen_first;
  logic [PRESS_W-1:0]        prev_pressure;
  logic [NOW_W-1:0]          last_one;
  logic [NOW_W-1:0]          last_two;

  // Result register
  logic                      out_valid;
  logic [VALUE_W-1:0]        out_value;
  logic [DOT_W-1:0]          out_dot;
  mode_t                     out_mode;
  logic signed [CHANGE_W-1:0] out_change;

  logic                      s_fire;
  logic                      out_free;
  logic                      s1_fire;
  logic                      is_sample;
  logic [NOW_W-1:0]          gap_one;
  logic [NOW_W-1:0]          gap_two;
  logic                      press_one_ok;
  logic                      press_two_ok;
  logic [PRESS_W-1:0]        prev_eff;
  logic signed [CHANGE_W-1:0] change;
  logic [VALUE_W-1:0]        fmt_value;
  logic [DOT_W-1:0]          fmt_dot;

  // The result register frees up when empty or when its word is taken.
  // A button word needs no result slot, so it drains even while m_axis stalls.
  assign out_free      = !out_valid || m_axis_tready;
  assign is_sample     = (s1_action == ACT_SAMPLE);
  assign s1_fire       = s1_valid && (out_free || !is_sample);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Debounce: elapsed ticks modulo 2^32 must strictly exceed the setting.
  assign gap_one      = s1_now - last_one;
  assign gap_two      = s1_now - last_two;
  assign press_one_ok = gap_one > {{(NOW_W - DEB_W){1'b0}}, debounce_ms};
  assign press_two_ok = gap_two > {{(NOW_W - DEB_W){1'b0}}, debounce_ms};

  always_comb begin
    mode_next = mode;
    case (s1_action)
      ACT_BUTTON_ONE: begin
        if (press_one_ok) begin
          mode_next = (mode == MODE_DELTA) ? MODE_PRESSURE : MODE_DELTA;
        end
      end
      ACT_BUTTON_TWO: begin
        if (press_two_ok) begin
          case (mode)
            MODE_TEMPERATURE: mode_next = MODE_ALTITUDE;
            MODE_ALTITUDE:    mode_next = MODE_PRESSURE;
            default:          mode_next = MODE_TEMPERATURE;
          endcase
        end
      end
      default: mode_next = mode;
    endcase
  end

  // First sample compares against itself, so its change is zero.
  assign prev_eff = seen_first ? prev_pressure : s1_pressure;
  assign change   = $signed({1'b0, s1_pressure}) - $signed({1'b0, prev_eff});

  bdmf_format u_format (
    .mode            (mode),
    .pressure        (s1_pressure),
    .pressure_change (change),
    .temp_tenths     (s1_temp),
    .altitude        (s1_alt),
    .display_value   (fmt_value),
    .dot_code        (fmt_dot)
  );

  // Capture an input word; hold it until it can move on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_action   <= action_t'(s_axis_tuser);
      s1_now      <= s_axis_tdata[31:0];
      s1_pressure <= s_axis_tdata[48:32];
      s1_temp     <= s_axis_tdata[60:49];
      s1_alt      <= s_axis_tdata[76:61];
    end
  end

  // Debounce setting; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_wen) begin
      debounce_ms <= cfg_wdata;
    end
  end

  // Advance mode and press history when a word leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PRESSURE;
      seen_first    <= 1'b0;
      prev_pressure <= '0;
      last_one      <= '0;
      last_two      <= '0;
    end else if (s1_fire) begin
      mode <= mode_next;
      if (s1_action == ACT_BUTTON_ONE && press_one_ok) begin
        last_one <= s1_now;
      end
      if (s1_action == ACT_BUTTON_TWO && press_two_ok) begin
        last_two <= s1_now;
      end
      if (is_sample) begin
        seen_first    <= 1'b1;
        prev_pressure <= s1_pressure;
      end
    end
  end

  // Result register: load on a sample, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && is_sample) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && is_sample) begin
      out_value  <= fmt_value;
      out_dot    <= fmt_dot;
      out_mode   <= mode;
      out_change <= change;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - CHANGE_W - DOT_W - VALUE_W){1'b0}},
                          out_change, out_dot, out_value};
  assign m_axis_tuser  = out_mode;

endmodule

// ----- src/bdmf_checker.sv -----
`include "barometer_display_mode_formatter_core_assert.svh"

module bdmf_checker
  import bdmf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [MODE_W-1:0]      m_axis_tuser
);

  logic [VALUE_W-1:0] value;
  logic [DOT_W-1:0]   dot;

  assign value = m_axis_tdata[13:0];
  assign dot   = m_axis_tdata[16:14];

  `BDMF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result word changed while stalled")

  `BDMF_ASSERT_IMP(a_value_range, m_axis_tvalid, value <= DISPLAY_MAX,
    "display value above 9999")

  `BDMF_ASSERT_IMP(a_pressure_dot, m_axis_tvalid && m_axis_tuser == MODE_PRESSURE,
    dot == DOT_POS0, "pressure mode without dot at position 0")

  `BDMF_ASSERT_IMP(a_nodot_modes,
    m_axis_tvalid && (m_axis_tuser == MODE_DELTA || m_axis_tuser == MODE_ALTITUDE),
    dot == DOT_NONE, "delta or altitude mode shows a dot")

  `BDMF_ASSERT_IMP(a_temp_dot, m_axis_tvalid && m_axis_tuser == MODE_TEMPERATURE,
    dot == DOT_POS1 || (dot == DOT_NONE && value == '0),
    "temperature dot and value disagree")

endmodule

bind barometer_display_mode_formatter_core bdmf_checker u_bdmf_checker (.*);

// ----- tb/bdmf_tb_pkg.sv -----
`timescale 1ns / 1ps
package bdmf_tb_pkg;
  import bdmf_pkg::*;

  localparam int unsigned OUT_USED_W    = VALUE_W + DOT_W + CHANGE_W;
  localparam int          HALF_HPA      = 50;
  localparam int          PA_PER_HPA    = 100;
  localparam int          TENTHS_SCALE  = 10;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [DOT_W-1:0]    dot;
    logic [MODE_W-1:0]   mode;
    logic [CHANGE_W-1:0] change;
  } readout_t;

  // Tracks mode, debounce and pressure history; queues one readout per sample word.
  class readout_tracker;
    logic [DEB_W-1:0]   debounce;
    mode_t              display_mode;
    bit                 primed;
    logic [PRESS_W-1:0] last_pressure;
    logic [NOW_W-1:0]   stamp_one;
    logic [NOW_W-1:0]   stamp_two;
    readout_t           awaited[$];
    int unsigned        failures;

    function new();
      debounce      = DEBOUNCE_RESET;
      display_mode  = MODE_PRESSURE;
      primed        = 1'b0;
      last_pressure = '0;
      stamp_one     = '0;
      stamp_two     = '0;
      failures      = 0;
    endfunction

    function void set_debounce(logic [DEB_W-1:0] v);
      debounce = v;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function logic [VALUE_W-1:0] four_digits(int v);
      if (v > int'(DISPLAY_MAX)) begin
        return DISPLAY_MAX;
      end
      return v[VALUE_W-1:0];
    endfunction

    function void note_input_word(logic [ACTION_W-1:0] kind, logic [IN_TDATA_W-1:0] data);
      logic [NOW_W-1:0]         now;
      logic [PRESS_W-1:0]       pa;
      logic signed [TEMP_W-1:0] tenths;
      logic signed [ALT_W-1:0]  alt;
      int                       change;
      int                       mag;
      readout_t                 r;
      now    = data[NOW_W-1:0];
      pa     = data[NOW_W +: PRESS_W];
      tenths = data[NOW_W+PRESS_W +: TEMP_W];
      alt    = data[NOW_W+PRESS_W+TEMP_W +: ALT_W];
      case (action_t'(kind))
        ACT_BUTTON_ONE: begin
          // elapsed time wraps at 32 bits
          if ((now - stamp_one) > debounce) begin
            stamp_one    = now;
            display_mode = (display_mode == MODE_DELTA) ? MODE_PRESSURE : MODE_DELTA;
          end
        end
        ACT_BUTTON_TWO: begin
          if ((now - stamp_two) > debounce) begin
            stamp_two = now;
            case (display_mode)
              MODE_TEMPERATURE: display_mode = MODE_ALTITUDE;
              MODE_ALTITUDE:    display_mode = MODE_PRESSURE;
              default:          display_mode = MODE_TEMPERATURE;
            endcase
          end
        end
        ACT_SAMPLE: begin
          if (!primed) begin
            last_pressure = pa;
            primed        = 1'b1;
          end
          change        = int'(pa) - int'(last_pressure);
          last_pressure = pa;
          r.mode   = display_mode;
          r.change = change[CHANGE_W-1:0];
          r.dot    = DOT_NONE;
          r.value  = '0;
          case (display_mode)
            MODE_DELTA: begin
              mag     = (change < 0) ? -change : change;
              r.value = four_digits(mag);
            end
            MODE_TEMPERATURE: begin
              if (tenths >= 0) begin
                r.value = four_digits(int'(tenths) * TENTHS_SCALE);
                r.dot   = DOT_POS1;
              end
            end
            MODE_ALTITUDE: begin
              if (alt >= 0) begin
                r.value = four_digits(int'(alt));
              end
            end
            default: begin
              r.value = four_digits((int'(pa) + HALF_HPA) / PA_PER_HPA);
              r.dot   = DOT_POS0;
            end
          endcase
          awaited.push_back(r);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_display_word(logic [OUT_TDATA_W-1:0] data, logic [MODE_W-1:0] user);
      readout_t want;
      readout_t got;
      got.value  = data[VALUE_W-1:0];
      got.dot    = data[VALUE_W +: DOT_W];
      got.change = data[VALUE_W+DOT_W +: CHANGE_W];
      got.mode   = user;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: unexpected display word value=%0d dot=%0d mode=%0d change=%0d",
                   $time, got.value, got.dot, got.mode, $signed(got.change));
        end
        return;
      end
      want = awaited.pop_front();
      if (got !== want || data[OUT_TDATA_W-1:OUT_USED_W] !== '0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: display word mismatch: want value=%0d dot=%0d mode=%0d change=%0d",
                   $time, want.value, want.dot, want.mode, $signed(want.change));
          $display("    got value=%0d dot=%0d mode=%0d change=%0d pad=%0h",
                   got.value, got.dot, got.mode, $signed(got.change),
                   data[OUT_TDATA_W-1:OUT_USED_W]);
        end
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_barometer_display_mode_formatter_core.sv -----
`timescale 1ns / 1ps
module tb_barometer_display_mode_formatter_core;
  import bdmf_pkg::*;
  import bdmf_tb_pkg::*;

  localparam int          PERIOD_NS    = 12;
  localparam int          LIMIT_NS     = 5_000_000;  // several times the slowest legal run
  localparam int unsigned HOLD_CYCLES  = 400;        // long sink hold-off, fills the block
  localparam int unsigned DRAIN_CYCLES = 4;          // covers a button word in the input register
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_WORDS  = 220;
  localparam int          PRESS_MAX    = (1 << PRESS_W) - 1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [DEB_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [MODE_W-1:0]      m_axis_tuser;

  readout_tracker tracker;

  // Idle control shared by the sender and the sink.
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned debounce_now = DEBOUNCE_RESET;
  logic [NOW_W-1:0] stream_ms = 32'd1000;
  int          pressure_walk = 101325;

  barometer_display_mode_formatter_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(PERIOD_NS / 2) clk = ~clk;

  // Sample both handshakes at the rising edge; check results before noting new words.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_display_word(m_axis_tdata, m_axis_tuser);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_input_word(s_axis_tuser, s_axis_tdata);
      end
    end
  end

  // Sink: stall in random bursts while idling is on; on request, hold off for a long
  // stretch so the sender keeps offering words into a full block.
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Offer one word and hold it until the block takes it. Every driving task starts at
  // the falling edge right after the previous acceptance, so no word is taken twice.
  task automatic send_word(action_t act, logic [NOW_W-1:0] now, logic [PRESS_W-1:0] pa,
                           logic [TEMP_W-1:0] tenths, logic [ALT_W-1:0] alt);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {{(IN_TDATA_W - NOW_W - PRESS_W - TEMP_W - ALT_W){1'b0}},
                     alt, tenths, pa, now};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop valid for a random burst now and then.
  task automatic sender_pause();
    int unsigned n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 18);
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop offering, wait for every queued readout, then let button words clear the pipe.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_debounce(logic [DEB_W-1:0] v);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_wen   = 1'b0;
    tracker.set_debounce(v);
    debounce_now = v;
  endtask

  // Directed part, run with the reset debounce of 200 ms.
  task automatic run_directed();
    // presses too early after reset, at and below the window
    send_word(ACT_BUTTON_ONE, 32'd100, '0, '0, '0);
    send_word(ACT_BUTTON_TWO, 32'd200, '0, '0, '0);
    // first sample reads zero change; then full-scale pressure
    send_word(ACT_SAMPLE, 32'd0, 17'd0, 12'd0, 16'd0);
    send_word(ACT_SAMPLE, 32'd0, 17'h1FFFF, 12'd0, 16'd0);
    // into delta: full negative swing saturates, small ones pass
    send_word(ACT_BUTTON_ONE, 32'd201, '0, '0, '0);
    send_word(ACT_SAMPLE, 32'd210, 17'd0, 12'd0, 16'd0);
    send_word(ACT_SAMPLE, 32'd220, 17'd50, 12'd0, 16'd0);
    send_word(ACT_BUTTON_ONE, 32'd401, '0, '0, '0);   // exactly at the window, ignored
    send_word(ACT_SAMPLE, 32'd230, 17'd149, 12'd0, 16'd0);
    // temperature: saturation, most negative, zero, top unsaturated
    send_word(ACT_BUTTON_TWO, 32'd201, '0, '0, '0);
    send_word(ACT_SAMPLE, 32'd240, 17'd149, 12'h7FF, 16'd0);
    send_word(ACT_SAMPLE, 32'd250, 17'd149, 12'h800, 16'd0);
    send_word(ACT_SAMPLE, 32'd260, 17'd149, 12'd0, 16'd0);
    send_word(ACT_SAMPLE, 32'd270, 17'd149, 12'd999, 16'd0);
    // altitude: largest, most negative, top unsaturated
    send_word(ACT_BUTTON_TWO, 32'd402, '0, '0, '0);
    send_word(ACT_SAMPLE, 32'd280, 17'd149, 12'd0, 16'h7FFF);
    send_word(ACT_SAMPLE, 32'd290, 17'd149, 12'd0, 16'h8000);
    send_word(ACT_SAMPLE, 32'd300, 17'd149, 12'd0, 16'd9999);
    // unused action, all ones
    send_word(ACT_UNUSED, 32'hFFFF_FFFF, 17'h1FFFF, 12'hFFF, 16'hFFFF);
    // button one across the 32-bit wrap: 200 ms elapsed is ignored, 201 ms toggles
    send_word(ACT_BUTTON_ONE, 32'hFFFF_FFFF, '0, '0, '0);
    send_word(ACT_BUTTON_ONE, 32'd199, '0, '0, '0);
    send_word(ACT_BUTTON_ONE, 32'd200, '0, '0, '0);
    // pressure rounding boundaries
    send_word(ACT_SAMPLE, 32'd310, 17'd49, 12'd0, 16'd0);
    send_word(ACT_SAMPLE, 32'd320, 17'd50, 12'd0, 16'd0);
    send_word(ACT_SAMPLE, 32'd330, 17'd150, 12'd0, 16'd0);
    // button two with a wrapped elapsed time, from pressure to temperature
    send_word(ACT_BUTTON_TWO, 32'd100, '0, '0, '0);
  endtask

  // One random word. Ticks mostly advance around the debounce window so presses land
  // on both sides of it; pressure walks slowly with jumps that reach the delta limit.
  task automatic random_word(output bit counted);
    int unsigned              roll;
    int unsigned              step;
    logic [31:0]              bits;
    action_t                  act;
    logic [NOW_W-1:0]         now;
    logic [TEMP_W-1:0]        tenths;
    logic [ALT_W-1:0]         alt;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      act = ACT_SAMPLE;
    end else if (roll < 75) begin
      act = ACT_BUTTON_ONE;
    end else if (roll < 95) begin
      act = ACT_BUTTON_TWO;
    end else begin
      act = ACT_UNUSED;
    end

    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      step = $urandom;
    end else if (roll < 10) begin
      step = debounce_now + $urandom_range(0, 1);
    end else begin
      step = $urandom_range(0, 2 * debounce_now + 2);
    end
    stream_ms = stream_ms + step;
    now = ($urandom_range(0, 99) < 3) ? $urandom : stream_ms;

    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      pressure_walk = $urandom_range(0, PRESS_MAX);
    end else if (roll < 20) begin
      if ($urandom_range(0, 1) == 1) begin
        pressure_walk = pressure_walk + int'($urandom_range(9990, 10010));
      end else begin
        pressure_walk = pressure_walk - int'($urandom_range(9990, 10010));
      end
    end else begin
      pressure_walk = pressure_walk + int'($urandom_range(0, 400)) - 200;
    end
    if (pressure_walk < 0) begin
      pressure_walk = 0;
    end else if (pressure_walk > PRESS_MAX) begin
      pressure_walk = PRESS_MAX;
    end

    bits   = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 1100);
    tenths = bits[TEMP_W-1:0];
    bits   = ($urandom_range(0, 9) < 4) ? $urandom : $urandom_range(0, 10100);
    alt    = bits[ALT_W-1:0];

    send_word(act, now, pressure_walk[PRESS_W-1:0], tenths, alt);
    counted = (act != ACT_UNUSED);
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      taken;
    bit               took;
    logic [DEB_W-1:0] next_deb;
    tracker = new();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Phase 0 keeps the reset debounce; later phases each write a new one, extremes included.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain();
        case (phase)
          1:       next_deb = '0;
          2:       next_deb = '1;
          4:       next_deb = 16'd1;
          6:       next_deb = DEBOUNCE_RESET;
          default: next_deb = DEB_W'($urandom_range(0, 65535));
        endcase
        write_debounce(next_deb);
      end
      // phase 1 and the last phase run without idling on either side
      idle_on = (phase != 1 && phase != PHASES - 1);
      if (phase == 3) begin
        hold_req = 1'b1;
      end
      taken = 0;
      while (taken < PHASE_WORDS) begin
        sender_pause();
        random_word(took);
        if (took) begin
          taken++;
        end
      end
    end

    drain();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit: a hang on either handshake ends here.
  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
